[rtl/assert_macros.svh]
// assertion macros used by the checker file xtn_checker.sv
// assumes clk and rst are visible where the macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// general property, disabled while in reset
`define XTN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// a value that holds over the cycle after a condition
`define XTN_ASSERT_HOLD(label, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

[rtl/xtn_pkg.sv]
// package for the xml text normaliser: character codes, result queue sizing,
// named-entity matcher tables and digit decoding; no dependencies
`default_nettype none

package xtn_pkg;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  localparam logic [7:0] STOP_BYTE_RESET = 8'h3C;

  localparam int unsigned DEC_DIGITS_MAX = 5;
  localparam int unsigned HEX_DIGITS_MAX = 4;
  localparam int unsigned REF_VALUE_MAX  = 255;

  // result queue: room for the two results one item may cause, plus drain slack
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0]  data;
    logic        is_end;
    logic        err;
    logic [31:0] line;
    logic        last;
  } res_t;

  // named-entity trie: next node, zero when the byte does not fit
  function automatic logic [3:0] ent_next(input logic [3:0] p, input logic [7:0] b);
    logic [3:0] nx;
    nx = '0;
    unique case (p)
      4'd0: begin
        if (b == "g") nx = 4'd1;
        else if (b == "l") nx = 4'd3;
        else if (b == "a") nx = 4'd5;
        else if (b == "q") nx = 4'd9;
      end
      4'd1:  if (b == "t") nx = 4'd2;
      4'd3:  if (b == "t") nx = 4'd4;
      4'd5: begin
        if (b == "p") nx = 4'd6;
        else if (b == "m") nx = 4'd13;
      end
      4'd6:  if (b == "o") nx = 4'd7;
      4'd7:  if (b == "s") nx = 4'd8;
      4'd9:  if (b == "u") nx = 4'd10;
      4'd10: if (b == "o") nx = 4'd11;
      4'd11: if (b == "t") nx = 4'd12;
      4'd13: if (b == "p") nx = 4'd14;
      default: nx = '0;
    endcase
    return nx;
  endfunction

  // decoded byte of a complete entity name, zero if the node is not a name end
  function automatic logic [7:0] ent_final(input logic [3:0] p);
    logic [7:0] v;
    unique case (p)
      4'd2:    v = ">";
      4'd4:    v = "<";
      4'd8:    v = "'";
      4'd12:   v = "\"";
      4'd14:   v = "&";
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // {valid, value} of a decimal or hex digit
  function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
    logic [4:0] r;
    r = '0;
    if (b >= "0" && b <= "9") r = {1'b1, 4'(b - 8'h30)};
    else if (hex && b >= "a" && b <= "f") r = {1'b1, 4'(b - 8'h57)};
    else if (hex && b >= "A" && b <= "F") r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/xml_text_normalizer.sv]
// Streaming normaliser for one run of XML text: drops leading whitespace,
// folds whitespace runs to one space, counts lines and decodes entity and
// character references. One byte is taken per clock while in_ready is high;
// each byte's results (none, one or two) are worked out in the same cycle and
// land in a four-entry result queue, which gives one result per clock while
// out_ready is high. A byte that causes two results takes two queue entries;
// in_ready stays high while the queue has two free entries, so with one result
// per byte and no back-pressure the block takes a byte per clock.
// Depends on xtn_pkg.
`default_nettype none

module xml_text_normalizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             is_end,
  output logic             malformed_ref,
  output logic [31:0]      line_count,
  output logic             last_for_input
);

  typedef enum logic [2:0] {
    PH_SKIP, PH_TEXT, PH_ENT, PH_HASH, PH_DEC, PH_HEX, PH_DISCARD
  } phase_t;

  localparam logic [xtn_pkg::QCW-1:0] QROOM = xtn_pkg::QCW'(xtn_pkg::QDEPTH - 2);

  phase_t       phase, phase_next;
  logic         space_pending, space_pending_next;
  logic [3:0]   entity_progress, entity_progress_next;
  logic [7:0]   ref_value, ref_value_next;
  logic [2:0]   digit_count, digit_count_next;
  logic [31:0]  line_counter;
  logic [7:0]   stop_byte;

  xtn_pkg::res_t          q [xtn_pkg::QDEPTH];
  logic [xtn_pkg::QAW-1:0] wptr, rptr;
  logic [xtn_pkg::QCW-1:0] count;

  logic         in_fire, out_fire;
  logic         ws, term, lf;
  logic         hex_mode;
  logic [7:0]   rv_eff;
  logic [2:0]   dc_eff;
  logic [4:0]   dig;
  logic [11:0]  acc;
  logic         over_len;
  logic [3:0]   ent_nx;
  logic [7:0]   ent_val;
  logic         count_lf, fail, restart;
  logic [1:0]   n_res;
  xtn_pkg::res_t r0, r1;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (count <= QROOM);

  assign ws   = (in_byte == xtn_pkg::CH_SPACE) || (in_byte == xtn_pkg::CH_TAB) ||
                (in_byte == xtn_pkg::CH_CR) || (in_byte == xtn_pkg::CH_LF);
  assign lf   = (in_byte == xtn_pkg::CH_LF);
  assign term = (in_byte == xtn_pkg::CH_NUL) || (in_byte == stop_byte);

  // digit path; the byte after '#' starts a fresh value, decimal unless it is 'x'
  assign hex_mode = (phase == PH_HEX);
  assign rv_eff   = (phase == PH_HASH) ? 8'd0 : ref_value;
  assign dc_eff   = (phase == PH_HASH) ? 3'd0 : digit_count;
  assign dig      = xtn_pkg::digit_of(in_byte, hex_mode);
  assign acc      = hex_mode ? ({4'd0, rv_eff} << 4) + {8'd0, dig[3:0]}
                             : ({4'd0, rv_eff} << 3) + ({4'd0, rv_eff} << 1) + {8'd0, dig[3:0]};
  assign over_len = hex_mode ? (dc_eff >= 3'(xtn_pkg::HEX_DIGITS_MAX))
                             : (dc_eff >= 3'(xtn_pkg::DEC_DIGITS_MAX));

  assign ent_nx  = xtn_pkg::ent_next(entity_progress, in_byte);
  assign ent_val = xtn_pkg::ent_final(entity_progress);

  always_comb begin
    phase_next           = phase;
    space_pending_next   = space_pending;
    entity_progress_next = entity_progress;
    ref_value_next       = ref_value;
    digit_count_next     = digit_count;
    count_lf             = 1'b0;
    fail                 = 1'b0;
    restart              = 1'b0;
    n_res                = 2'd0;
    r0                   = '0;
    r1                   = '0;
    r0.line              = line_counter;
    r1.line              = line_counter;

    unique case (phase)
      PH_SKIP, PH_TEXT: begin
        if ((phase == PH_SKIP && ws) || (space_pending && ws)) begin
          count_lf = lf;
        end else if (term) begin
          r0.is_end = 1'b1;
          n_res     = 2'd1;
          restart   = 1'b1;
        end else if (ws) begin
          count_lf           = lf;
          space_pending_next = 1'b1;
        end else begin
          phase_next         = PH_TEXT;
          space_pending_next = 1'b0;
          if (in_byte == xtn_pkg::CH_AMP) begin
            phase_next           = PH_ENT;
            entity_progress_next = '0;
            if (space_pending) begin
              r0.data = xtn_pkg::CH_SPACE;
              n_res   = 2'd1;
            end
          end else if (space_pending) begin
            r0.data = xtn_pkg::CH_SPACE;
            r1.data = in_byte;
            n_res   = 2'd2;
          end else begin
            r0.data = in_byte;
            n_res   = 2'd1;
          end
        end
      end
      PH_ENT: begin
        if (entity_progress == 4'd0 && in_byte == xtn_pkg::CH_HASH) begin
          phase_next = PH_HASH;
        end else if (in_byte == xtn_pkg::CH_SEMI && ent_val != 8'h00) begin
          r0.data              = ent_val;
          n_res                = 2'd1;
          phase_next           = PH_TEXT;
          entity_progress_next = '0;
        end else if (ent_nx != 4'd0) begin
          entity_progress_next = ent_nx;
        end else begin
          fail = 1'b1;
        end
      end
      PH_HASH, PH_DEC, PH_HEX: begin
        if (phase == PH_HASH) begin
          ref_value_next   = '0;
          digit_count_next = '0;
        end
        if (phase == PH_HASH && in_byte == xtn_pkg::CH_X) begin
          phase_next = PH_HEX;
        end else begin
          if (phase == PH_HASH) phase_next = PH_DEC;
          if (in_byte == xtn_pkg::CH_SEMI) begin
            if (dc_eff == 3'd0) begin
              fail = 1'b1;
            end else begin
              r0.data    = rv_eff;
              n_res      = 2'd1;
              phase_next = PH_TEXT;
            end
          end else if (!dig[4] || over_len || acc > 12'(xtn_pkg::REF_VALUE_MAX)) begin
            fail = 1'b1;
          end else begin
            ref_value_next   = acc[7:0];
            digit_count_next = dc_eff + 3'd1;
          end
        end
      end
      PH_DISCARD: begin
        if (term) begin
          r0.is_end = 1'b1;
          n_res     = 2'd1;
          restart   = 1'b1;
        end
      end
      default: restart = 1'b1;
    endcase

    // a broken reference reports, then closes the run if the byte ends it
    if (fail) begin
      r0.err = 1'b1;
      n_res  = 2'd1;
      if (term) begin
        r1.is_end = 1'b1;
        n_res     = 2'd2;
        restart   = 1'b1;
      end else begin
        phase_next = PH_DISCARD;
      end
    end

    if (restart) begin
      phase_next           = PH_SKIP;
      space_pending_next   = 1'b0;
      entity_progress_next = '0;
      ref_value_next       = '0;
      digit_count_next     = '0;
    end

    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SKIP;
      space_pending   <= 1'b0;
      entity_progress <= '0;
      ref_value       <= '0;
      digit_count     <= '0;
      line_counter    <= 32'd1;
      stop_byte       <= xtn_pkg::STOP_BYTE_RESET;
      wptr            <= '0;
      rptr            <= '0;
      count           <= '0;
    end else begin
      if (cfg_wr_en) stop_byte <= cfg_wr_data;
      if (in_fire) begin
        phase           <= phase_next;
        space_pending   <= space_pending_next;
        entity_progress <= entity_progress_next;
        ref_value       <= ref_value_next;
        digit_count     <= digit_count_next;
        if (count_lf && line_counter != '1) line_counter <= line_counter + 32'd1;
        wptr <= wptr + xtn_pkg::QAW'(n_res);
      end
      if (out_fire) rptr <= rptr + 1'b1;
      count <= count + (in_fire ? xtn_pkg::QCW'(n_res) : '0)
                     - xtn_pkg::QCW'(out_fire);
    end
    // queue payload, no reset
    if (!rst && in_fire) begin
      if (n_res != 2'd0) q[wptr] <= r0;
      if (n_res == 2'd2) q[wptr + 1'b1] <= r1;
    end
  end

  assign out_valid      = (count != '0);
  assign out_byte       = q[rptr].data;
  assign is_end         = q[rptr].is_end;
  assign malformed_ref  = q[rptr].err;
  assign line_count     = q[rptr].line;
  assign last_for_input = q[rptr].last;

endmodule

`default_nettype wire

[rtl/xtn_checker.sv]
// port-level checks for xml_text_normalizer, bound into every instance of it
// uses the macros in assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module xtn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_byte,
  input wire logic        is_end,
  input wire logic        malformed_ref,
  input wire logic [31:0] line_count,
  input wire logic        last_for_input
);

  // a stalled result keeps its fields
  `XTN_ASSERT_HOLD(a_out_hold, out_valid && !out_ready, ({out_byte, is_end, malformed_ref, line_count, last_for_input}), "result changed while stalled")

  `XTN_ASSERT(a_end_err_excl, out_valid |-> !(is_end && malformed_ref), "end and error on one result")

  `XTN_ASSERT(a_flag_zero, out_valid && (is_end || malformed_ref) |-> out_byte == 8'h00, "end or error result carries a byte")

  `XTN_ASSERT(a_end_last, out_valid && is_end |-> last_for_input, "end result is not the last of its item")

  // an error that is not last is followed straight away by the end of the run
  `XTN_ASSERT(a_err_then_end, out_valid && out_ready && malformed_ref && !last_for_input |=> out_valid && is_end, "error not followed by end")

endmodule

bind xml_text_normalizer xtn_checker u_xtn_checker (.*);

`default_nettype wire
